// File: rtl/assert_macros.svh
// assertion macros used by the rtl top level
// both macros expect signals named clk and rst in the using scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CHT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("chained hash table assertion failed");

// antecedent implies consequent in the next cycle
`define CHT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("chained hash table assertion failed");

`endif

// File: rtl/cht_pkg.sv
// shared types and constants of the chained hash table
// no dependencies
package cht_pkg;

  localparam int MODE_W   = 2;
  localparam int KEY_W    = 31;
  localparam int VAL_W    = 16;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 8;

  localparam logic [CFG_W-1:0] CFG_RESET = 8'd100;

  // remainder unit: DIV_BITS quotient bits per cycle
  localparam int DIV_BITS  = 4;
  localparam int DIV_STEPS = (KEY_W + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_PAD_W = DIV_STEPS * DIV_BITS;
  localparam int DIV_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 2'd0,
    MODE_FIND   = 2'd1,
    MODE_DELETE = 2'd2
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_MISSING = 2'd2
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

endpackage

// File: rtl/cht_if.sv
// request and response channel interfaces of the chained hash table
// depends on cht_pkg
interface cht_req_if;
  import cht_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [KEY_W-1:0]  key;
  logic [VAL_W-1:0]  value;

  modport source (output valid, mode, key, value, input ready);
  modport sink   (input valid, mode, key, value, output ready);
endinterface

interface cht_rsp_if;
  import cht_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                found;
  logic [VAL_W-1:0]    found_value;

  modport source (output valid, status, found, found_value, input ready);
  modport sink   (input valid, status, found, found_value, output ready);
endinterface

// File: rtl/cht_mod_unit.sv
// iterative remainder unit: key modulo bucket count, DIV_BITS bits per cycle
// depends on cht_pkg
module cht_mod_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [cht_pkg::KEY_W-1:0] dividend,
  input  logic [cht_pkg::CFG_W-1:0] divisor,
  output logic                      done,
  output logic [cht_pkg::CFG_W-1:0] rem
);
  import cht_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_PAD_W-1:0] shift;
  logic [CFG_W-1:0]     rem_acc;
  logic [DIV_PAD_W-1:0] shift_next;
  logic [CFG_W-1:0]     rem_next;

  // restoring steps, remainder stays below the divisor so 9 bits suffice
  always_comb begin : step_logic
    logic [CFG_W:0]       t;
    logic [CFG_W-1:0]     r;
    logic [DIV_PAD_W-1:0] s;
    r = rem_acc;
    s = shift;
    for (int j = 0; j < DIV_BITS; j++) begin
      t = {r, s[DIV_PAD_W-1]};
      s = {s[DIV_PAD_W-2:0], 1'b0};
      if (t >= {1'b0, divisor}) begin
        t = t - {1'b0, divisor};
      end
      r = t[CFG_W-1:0];
    end
    rem_next   = r;
    shift_next = s;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shift   <= DIV_PAD_W'(dividend);
      rem_acc <= '0;
    end else if (busy) begin
      shift   <= shift_next;
      rem_acc <= rem_next;
    end
  end

  assign rem = rem_acc;

endmodule

// File: rtl/cht_mem.sv
// bucket fill memory and entry memory, one write and one read port each
// read data is registered; depends on cht_pkg
module cht_mem #(
  parameter int NUM_BUCKETS = 128,
  parameter int WAYS        = 4
) (
  input  logic                                    clk,
  input  logic                                    fill_we,
  input  logic [$clog2(NUM_BUCKETS)-1:0]          fill_waddr,
  input  logic [$clog2(WAYS+1)-1:0]               fill_wdata,
  input  logic [$clog2(NUM_BUCKETS)-1:0]          fill_raddr,
  output logic [$clog2(WAYS+1)-1:0]               fill_rdata,
  input  logic                                    ent_we,
  input  logic [$clog2(NUM_BUCKETS)+((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] ent_waddr,
  input  cht_pkg::entry_t                         ent_wdata,
  input  logic [$clog2(NUM_BUCKETS)+((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] ent_raddr,
  output cht_pkg::entry_t                         ent_rdata
);
  import cht_pkg::*;

  localparam int SLOT_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ENT_DEPTH = NUM_BUCKETS << SLOT_W;

  logic [$clog2(WAYS+1)-1:0] fill_ram [NUM_BUCKETS];
  entry_t                    ent_ram  [ENT_DEPTH];

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_ram[fill_waddr] <= fill_wdata;
    end
    fill_rdata <= fill_ram[fill_raddr];
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_ram[ent_waddr] <= ent_wdata;
    end
    ent_rdata <= ent_ram[ent_raddr];
  end

endmodule

// File: rtl/chained_hash_table_top.sv
// top level of the chained hash table: control sequencer, config register
// depends on cht_pkg, cht_if, cht_mod_unit, cht_mem, assert_macros.svh
`include "assert_macros.svh"
// usage
//  req channel: one transaction per operation (mode, key, value)
//  rsp channel: exactly one transaction per request (status, found, found_value)
//  cfg_we/cfg_data: writes bucket_count, only while the block is idle
// timing
//  one request is processed at a time; insert and other modes pass through
//  the divide, fill read, lookup and finish states, and find and delete add
//  a bucket scan between lookup and finish
//  the next request is taken in the cycle after the response is loaded
//  the remainder unit and the one-entry-per-cycle bucket scan through the
//  entry memory read port set the time that each request takes
// reset
//  rst clears control and sets bucket_count to 100, then a clearing pass over
//  every bucket zeroes the fill memory; req.ready stays low meanwhile
// stall
//  the response sits in an output register; the next request is taken while
//  it waits, and processing holds at its last cycle until the register frees
module chained_hash_table_top #(
  parameter int NUM_BUCKETS = 128,
  parameter int WAYS        = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  cht_req_if.sink                   req,
  cht_rsp_if.source                 rsp,
  input  logic                      cfg_we,
  input  logic [cht_pkg::CFG_W-1:0] cfg_data
);
  import cht_pkg::*;

  localparam int BKT_W  = $clog2(NUM_BUCKETS);
  localparam int FILL_W = $clog2(WAYS + 1);
  localparam int SLOT_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ENT_AW = BKT_W + SLOT_W;

  typedef enum logic [6:0] {
    S_CLEAR   = 7'b0000001,
    S_IDLE    = 7'b0000010,
    S_DIVIDE  = 7'b0000100,
    S_FILL_RD = 7'b0001000,
    S_LOOKUP  = 7'b0010000,
    S_SCAN    = 7'b0100000,
    S_FINISH  = 7'b1000000
  } state_t;

  state_t state;

  // config register
  logic [CFG_W-1:0] bucket_count;
  logic [CFG_W-1:0] div_val;
  logic [CFG_W-1:0] div_r;

  // latched request
  mode_t            mode_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] val_r;
  logic [BKT_W-1:0] bkt;
  logic [FILL_W-1:0] fill;

  // scan control
  logic [FILL_W-1:0] rd_idx;
  logic              pend;
  logic [SLOT_W-1:0] pend_idx;
  logic              matched;
  logic              issue;
  logic              scan_end;
  logic              hit;

  // clearing pass
  logic [BKT_W-1:0] clr_idx;

  // pending result and output register
  status_t          res_status;
  logic             res_found;
  logic [VAL_W-1:0] res_value;
  logic             out_valid;
  status_t          out_status;
  logic             out_found;
  logic [VAL_W-1:0] out_value;

  // remainder unit
  logic             mod_done;
  logic [CFG_W-1:0] mod_rem;

  // memory ports
  logic              fill_we;
  logic [BKT_W-1:0]  fill_waddr;
  logic [FILL_W-1:0] fill_wdata;
  logic [FILL_W-1:0] fill_rdata;
  logic              ent_we;
  logic [ENT_AW-1:0] ent_waddr;
  entry_t            ent_wdata;
  logic [ENT_AW-1:0] ent_raddr;
  entry_t            ent_rdata;

  logic accept;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);

  // zero counts as one bucket, oversized counts clamp to the table size
  always_comb begin
    div_val = bucket_count;
    if (bucket_count == '0) begin
      div_val = CFG_W'(1);
    end else if (int'(bucket_count) > NUM_BUCKETS) begin
      div_val = CFG_W'(NUM_BUCKETS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= CFG_RESET;
    end else if (cfg_we) begin
      bucket_count <= cfg_data;
    end
  end

  cht_mod_unit u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (accept),
    .dividend (req.key),
    .divisor  (div_val),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  cht_mem #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .WAYS        (WAYS)
  ) u_mem (
    .clk        (clk),
    .fill_we    (fill_we),
    .fill_waddr (fill_waddr),
    .fill_wdata (fill_wdata),
    .fill_raddr (bkt),
    .fill_rdata (fill_rdata),
    .ent_we     (ent_we),
    .ent_waddr  (ent_waddr),
    .ent_wdata  (ent_wdata),
    .ent_raddr  (ent_raddr),
    .ent_rdata  (ent_rdata)
  );

  // scan: one entry read issued per cycle, checked when its data returns;
  // a find stops issuing once it has matched, a delete keeps reading and
  // moves each later entry down one slot
  assign issue     = (state == S_SCAN) && (rd_idx < fill) &&
                     !(matched && (mode_r == MODE_FIND));
  assign scan_end  = (state == S_SCAN) && !pend &&
                     ((rd_idx >= fill) || (matched && (mode_r == MODE_FIND)));
  assign hit       = (ent_rdata.key == key_r);
  assign ent_raddr = {bkt, rd_idx[SLOT_W-1:0]};

  // memory write selection; writes never target a slot still to be read,
  // and the fill write of one request lands long before the next reads it
  always_comb begin
    fill_we    = 1'b0;
    fill_waddr = bkt;
    fill_wdata = '0;
    ent_we     = 1'b0;
    ent_waddr  = {bkt, fill_rdata[SLOT_W-1:0]};
    ent_wdata  = '{key: key_r, value: val_r};
    case (state)
      S_CLEAR: begin
        fill_we    = 1'b1;
        fill_waddr = clr_idx;
      end
      S_LOOKUP: begin
        if ((mode_r == MODE_INSERT) && (fill_rdata < FILL_W'(WAYS))) begin
          fill_we    = 1'b1;
          fill_wdata = fill_rdata + 1'b1;
          ent_we     = 1'b1;
        end
      end
      S_SCAN: begin
        if (pend && matched && (mode_r == MODE_DELETE)) begin
          ent_we    = 1'b1;
          ent_waddr = {bkt, pend_idx - 1'b1};
          ent_wdata = ent_rdata;
        end
        if (scan_end && matched && (mode_r == MODE_DELETE)) begin
          fill_we    = 1'b1;
          fill_wdata = fill - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      pend      <= 1'b0;
      matched   <= 1'b0;
      rd_idx    <= '0;
      out_valid <= 1'b0;
    end else begin
      // output register: loaded from the result stage, freed by the receiver
      if ((state == S_FINISH) && (!out_valid || rsp.ready)) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == BKT_W'(NUM_BUCKETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= S_DIVIDE;
          end
        end
        S_DIVIDE: begin
          if (mod_done) begin
            state <= S_FILL_RD;
          end
        end
        S_FILL_RD: begin
          state <= S_LOOKUP;
        end
        S_LOOKUP: begin
          pend    <= 1'b0;
          matched <= 1'b0;
          rd_idx  <= '0;
          if ((mode_r == MODE_FIND) || (mode_r == MODE_DELETE)) begin
            state <= S_SCAN;
          end else begin
            state <= S_FINISH;
          end
        end
        S_SCAN: begin
          pend <= issue;
          if (issue) begin
            rd_idx <= rd_idx + 1'b1;
          end
          if (pend && !matched && hit) begin
            matched <= 1'b1;
          end
          if (scan_end) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!out_valid || rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_CLEAR;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r     <= mode_t'(req.mode);
      key_r      <= req.key;
      val_r      <= req.value;
      div_r      <= div_val;
      res_status <= ST_DONE;
      res_found  <= 1'b0;
      res_value  <= '0;
    end
    if ((state == S_DIVIDE) && mod_done) begin
      bkt <= BKT_W'(mod_rem);
    end
    if (state == S_LOOKUP) begin
      fill <= fill_rdata;
      if ((mode_r == MODE_INSERT) && (fill_rdata >= FILL_W'(WAYS))) begin
        res_status <= ST_FULL;
      end
    end
    if ((state == S_SCAN) && pend && !matched && hit && (mode_r == MODE_FIND)) begin
      res_value <= ent_rdata.value;
    end
    if (state == S_SCAN) begin
      pend_idx <= rd_idx[SLOT_W-1:0];
    end
    if (scan_end) begin
      res_found  <= matched;
      res_status <= matched ? ST_DONE : ST_MISSING;
    end
    if ((state == S_FINISH) && (!out_valid || rsp.ready)) begin
      out_status <= res_status;
      out_found  <= res_found;
      out_value  <= res_value;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.found       = out_found;
  assign rsp.found_value = out_value;

  // a bucket never reports more entries than it has slots
  `CHT_ASSERT_SAME(a_fill_bound, state == S_LOOKUP, fill_rdata <= FILL_W'(WAYS))
  // the remainder handed to the lookup lies below the latched modulus
  `CHT_ASSERT_SAME(a_rem_range, mod_done, mod_rem < div_r)
  // the scan never runs past the bucket's fill count
  `CHT_ASSERT_SAME(a_scan_bound, state == S_SCAN, rd_idx <= fill)
  // leaving the scan always goes straight to the result stage
  `CHT_ASSERT_NEXT(a_scan_exit, scan_end, state == S_FINISH)

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench of chained_hash_table_top: directed and random insert, find
// and delete traffic, checked against a scoreboard that keeps its own copy of the table
// depends on cht_pkg, cht_req_if/cht_rsp_if and the rtl of chained_hash_table_top
module testbench;
  import cht_pkg::*;

  localparam int NUM_BUCKETS = 128;
  localparam int WAYS        = 4;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  // cycles left to the block after the last response, well over its longest latency
  localparam int TAIL_CYCLES = 40;
  // long receiver hold-off, enough to fill the block and back up the request side
  localparam int LONG_HOLD   = 400;
  localparam int PHASE_ITEMS = 168;
  localparam int POOL_SIZE   = 10;

  typedef struct {
    status_t          status;
    logic             found;
    logic [VAL_W-1:0] found_value;
  } table_result_t;

  // scoreboard: mirrors the table contents and holds the results still owed by the block
  class table_scoreboard;
    logic [CFG_W-1:0] bucket_count;
    int unsigned      fill[NUM_BUCKETS];
    logic [KEY_W-1:0] slot_key[NUM_BUCKETS*WAYS];
    logic [VAL_W-1:0] slot_val[NUM_BUCKETS*WAYS];
    table_result_t    owed_q[$];
    int unsigned      mismatches;

    function new();
      bucket_count = CFG_RESET;
      foreach (fill[i]) fill[i] = 0;
      mismatches = 0;
    endfunction

    function void set_bucket_count(logic [CFG_W-1:0] cnt);
      bucket_count = cnt;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // first matching slot within a bucket, WAYS when there is none
    function int unsigned first_hit(int unsigned bucket, logic [KEY_W-1:0] key);
      for (int unsigned i = 0; i < fill[bucket]; i++)
        if (slot_key[bucket*WAYS + i] == key) return i;
      return WAYS;
    endfunction

    // accepted request: update the table copy and queue the result it causes
    function void note_request(logic [MODE_W-1:0] mode, logic [KEY_W-1:0] key,
                               logic [VAL_W-1:0] value);
      int unsigned   nb;
      int unsigned   bucket;
      int unsigned   base;
      int unsigned   hit;
      table_result_t res;
      nb = (bucket_count == 0) ? 1 : ((bucket_count > NUM_BUCKETS) ? NUM_BUCKETS
                                                                    : bucket_count);
      bucket = int'({1'b0, key}) % nb;
      base = bucket * WAYS;
      res.status = ST_DONE;
      res.found = 1'b0;
      res.found_value = '0;
      case (mode)
        MODE_INSERT: begin
          if (fill[bucket] >= WAYS) begin
            res.status = ST_FULL;
          end else begin
            slot_key[base + fill[bucket]] = key;
            slot_val[base + fill[bucket]] = value;
            fill[bucket]++;
          end
        end
        MODE_FIND: begin
          hit = first_hit(bucket, key);
          if (hit < WAYS) begin
            res.found = 1'b1;
            res.found_value = slot_val[base + hit];
          end else begin
            res.status = ST_MISSING;
          end
        end
        MODE_DELETE: begin
          hit = first_hit(bucket, key);
          if (hit < WAYS) begin
            res.found = 1'b1;
            // close the gap, keeping insertion order
            for (int unsigned i = hit; i + 1 < fill[bucket]; i++) begin
              slot_key[base + i] = slot_key[base + i + 1];
              slot_val[base + i] = slot_val[base + i + 1];
            end
            fill[bucket]--;
          end else begin
            res.status = ST_MISSING;
          end
        end
        default: ;  // unused mode leaves the table alone
      endcase
      owed_q.push_back(res);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_response(logic [STATUS_W-1:0] status, logic found,
                        logic [VAL_W-1:0] found_value);
      table_result_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("response with none owed (status %0d)", status));
      end else begin
        want = owed_q.pop_front();
        if (status !== want.status)
          report($sformatf("status got %0d want %0d", status, want.status));
        if (found !== want.found)
          report($sformatf("found got %0d want %0d", found, want.found));
        if (found_value !== want.found_value)
          report($sformatf("found_value got %0h want %0h", found_value, want.found_value));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_data;

  // flags set by the stimulus; rsp_quiet and hold_request steer the response side
  bit req_quiet;
  bit rsp_quiet;
  bit hold_request;

  table_scoreboard sb = new();

  cht_req_if req_ch();
  cht_rsp_if rsp_ch();

  chained_hash_table_top #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .WAYS        (WAYS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch.sink),
    .rsp      (rsp_ch.source),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  // one request transaction: optional gap, then hold valid until ready
  task send_op(input logic [MODE_W-1:0] mode, input logic [KEY_W-1:0] key,
               input logic [VAL_W-1:0] value);
    int unsigned gap;
    gap = req_quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode  <= mode;
    req_ch.key   <= key;
    req_ch.value <= value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(mode, key, value);
  endtask

  // drop valid right after the last accepted transaction, before any pause
  task stop_sending();
    req_ch.valid <= 1'b0;
  endtask

  task drain_results();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // bucket_count is only written with the block idle
  task write_bucket_count(input logic [CFG_W-1:0] cnt);
    stop_sending();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= cnt;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.set_bucket_count(cnt);
  endtask

  // random traffic around a key pool that crowds one bucket, plus stray keys
  task random_phase(input int phase);
    logic [KEY_W-1:0]  pool[POOL_SIZE];
    int unsigned       nb;
    int unsigned       anchor;
    int unsigned       pick;
    logic [MODE_W-1:0] mode;
    logic [KEY_W-1:0]  key;
    nb = (sb.bucket_count == 0) ? 1
         : ((sb.bucket_count > NUM_BUCKETS) ? NUM_BUCKETS : sb.bucket_count);
    anchor = $urandom_range(0, nb - 1);
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i < 6) pool[i] = KEY_W'(anchor + i * nb);  // more than WAYS keys on one bucket
      else pool[i] = KEY_W'($urandom());
    end
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      // even phases open with a stretch of back-to-back traffic on both sides
      req_quiet = (phase % 2 == 0) && (n < PHASE_ITEMS / 2);
      rsp_quiet = req_quiet;
      if (phase == 2 && n == 20) hold_request = 1'b1;
      if (phase == 5 && n == 80) begin
        // sender pause until every owed result has come back
        stop_sending();
        drain_results();
      end
      pick = $urandom_range(0, 99);
      if (pick < 40) mode = MODE_INSERT;
      else if (pick < 70) mode = MODE_FIND;
      else if (pick < 95) mode = MODE_DELETE;
      else mode = MODE_UNUSED;
      if ($urandom_range(0, 99) < 80) key = pool[$urandom_range(0, POOL_SIZE - 1)];
      else key = KEY_W'($urandom());
      send_op(mode, key, VAL_W'($urandom_range(0, 65535)));
    end
  endtask

  // response side: random hold-offs, one long one on request
  initial begin : response_sink
    int unsigned stall;
    rsp_ch.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        stall = LONG_HOLD;
        hold_request = 1'b0;
      end else begin
        stall = rsp_quiet ? 0 : $urandom_range(0, 15);
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      sb.check_response(rsp_ch.status, rsp_ch.found, rsp_ch.found_value);
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] settings[10];
    settings = '{8'd1, 8'd2, 8'd128, 8'd0, 8'd255, 8'd100, 8'd3, 8'd200, 8'd64, 8'd129};
    req_ch.valid = 1'b0;
    req_ch.mode  = MODE_INSERT;
    req_ch.key   = '0;
    req_ch.value = '0;
    cfg_we       = 1'b0;
    cfg_data     = '0;
    req_quiet    = 1'b0;
    rsp_quiet    = 1'b0;
    hold_request = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed part, bucket_count at its reset value of 100
    send_op(MODE_INSERT, '0, '0);
    send_op(MODE_INSERT, {KEY_W{1'b1}}, {VAL_W{1'b1}});
    send_op(MODE_FIND, {KEY_W{1'b1}}, '0);
    send_op(MODE_FIND, '0, 16'h5a5a);            // value ignored on find
    send_op(MODE_INSERT, '0, 16'h1234);          // duplicate key
    send_op(MODE_FIND, '0, '0);                  // first of the duplicates
    send_op(MODE_DELETE, '0, 16'hffff);
    send_op(MODE_FIND, '0, '0);                  // now the second one
    send_op(MODE_DELETE, 31'd5, '0);             // missing key
    send_op(MODE_FIND, 31'd5, '0);
    // fill bucket 7, then overflow it
    send_op(MODE_INSERT, 31'd7, 16'h0007);
    send_op(MODE_INSERT, 31'd107, 16'h0107);
    send_op(MODE_INSERT, 31'd207, 16'h0207);
    send_op(MODE_INSERT, 31'd307, 16'h0307);
    send_op(MODE_INSERT, 31'd407, 16'h0407);
    send_op(MODE_DELETE, 31'd107, '0);           // middle entry, rest shift down
    send_op(MODE_FIND, 31'd207, '0);
    send_op(MODE_FIND, 31'd307, '0);
    send_op(MODE_INSERT, 31'd507, 16'h0507);
    send_op(MODE_FIND, 31'd507, '0);
    send_op(MODE_UNUSED, 31'd7, 16'hffff);       // unused mode
    send_op(MODE_FIND, 31'd7, '0);
    send_op(MODE_DELETE, {KEY_W{1'b1}}, '0);

    // random part over several bucket counts, extremes among them
    for (int phase = 0; phase < 10; phase++) begin
      write_bucket_count(settings[phase]);
      random_phase(phase);
    end

    stop_sending();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  // run limit, far above the slowest correct run
  initial begin : watchdog
    #5ms;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
